@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker module of the lexer core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the reset is high.
`define CHK_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lexer core assertion failed");

// Clocked assertion that is also checked during reset.
`define CHK_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("lexer core assertion failed");

`endif

@@ rtl/core/irlex_pkg.sv @@
// Constants, types and helper functions of the IR token lexer core.
package irlex_pkg;

   localparam int MAX_NAME_CHARS     = 20;
   localparam int BUF_CHARS          = 24;
   localparam int NAME_LIMIT         = (MAX_NAME_CHARS < BUF_CHARS) ? MAX_NAME_CHARS
                                                                    : BUF_CHARS;
   localparam int MAX_LITERAL_DIGITS = 20;
   localparam int NAME_CHUNKS        = (NAME_LIMIT + 7) / 8;
   localparam int MAX_RESULTS        = NAME_CHUNKS + 1;
   localparam int NAME_IDX_W         = $clog2(NAME_LIMIT);
   localparam int RES_CNT_W          = $clog2(MAX_RESULTS + 1);
   localparam int RES_IDX_W          = $clog2(MAX_RESULTS);
   localparam int FIFO_DEPTH         = 8;
   localparam int FIFO_PTR_W         = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W         = $clog2(FIFO_DEPTH + 1);

   localparam logic [4:0]  NAME_CNT_LIMIT  = 5'(NAME_LIMIT);
   localparam logic [4:0]  LIT_DIGIT_LIMIT = 5'(MAX_LITERAL_DIGITS);
   localparam logic [62:0] MANT_MAX        = {63{1'b1}};

   // Token kinds.
   localparam logic [4:0] KIND_ADD     = 5'd0;
   localparam logic [4:0] KIND_MINUS   = 5'd1;
   localparam logic [4:0] KIND_MULT    = 5'd2;
   localparam logic [4:0] KIND_DIV     = 5'd3;
   localparam logic [4:0] KIND_EQ      = 5'd4;
   localparam logic [4:0] KIND_COLON   = 5'd5;
   localparam logic [4:0] KIND_COMMA   = 5'd6;
   localparam logic [4:0] KIND_LPAREN  = 5'd7;
   localparam logic [4:0] KIND_RPAREN  = 5'd8;
   localparam logic [4:0] KIND_JMPIF   = 5'd9;
   localparam logic [4:0] KIND_JMP     = 5'd10;
   localparam logic [4:0] KIND_PHI     = 5'd11;
   localparam logic [4:0] KIND_IDENT   = 5'd12;
   localparam logic [4:0] KIND_INT     = 5'd13;
   localparam logic [4:0] KIND_DECIMAL = 5'd14;
   localparam logic [4:0] KIND_END     = 5'd15;
   localparam logic [4:0] KIND_ERROR   = 5'd16;

   // Error codes.
   localparam logic [1:0] ERR_NAME_LONG  = 2'd0;
   localparam logic [1:0] ERR_LIT_LONG   = 2'd1;
   localparam logic [1:0] ERR_UNEXPECTED = 2'd2;

   // Lexer modes.
   localparam logic [2:0] MODE_IDLE = 3'd0;
   localparam logic [2:0] MODE_NAME = 3'd1;
   localparam logic [2:0] MODE_INT  = 3'd2;
   localparam logic [2:0] MODE_FRAC = 3'd3;
   localparam logic [2:0] MODE_DROP = 3'd4;

   // Source characters.
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;

   localparam logic [39:0] KW_JMPIF = "jmpif";
   localparam logic [23:0] KW_JMP   = "jmp";
   localparam logic [23:0] KW_PHI   = "phi";

   typedef struct packed {
      logic [2:0]  mode;
      logic [4:0]  name_count;
      logic [62:0] mantissa;
      logic [4:0]  digit_count;
      logic [4:0]  frac_count;
   } lex_state_type;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [62:0] literal_mantissa;
      logic [4:0]  fraction_digits;
      logic [63:0] name_chunk;
      logic [1:0]  chunk_index;
      logic [4:0]  name_length;
      logic [1:0]  error_code;
      logic [7:0]  offending_byte;
      logic        last_of_token;
   } lex_result_type;

   typedef struct packed {
      logic                  en;
      logic [NAME_IDX_W-1:0] addr;
      logic [7:0]            data;
   } buf_write_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
             (c == CH_UNDERSCORE);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic lex_result_type single_result(input logic [4:0] kind);
      lex_result_type r;
      r               = '0;
      r.token_kind    = kind;
      r.last_of_token = 1'b1;
      return r;
   endfunction

   function automatic lex_result_type error_result(input logic [1:0] code,
                                                   input logic [7:0] byte_val);
      lex_result_type r;
      r                = single_result(KIND_ERROR);
      r.error_code     = code;
      r.offending_byte = byte_val;
      return r;
   endfunction

endpackage

@@ rtl/core/ir_token_lexer_core.sv @@
// Top level of the IR token lexer: lexer state, name buffer and result queue.
//
// Usage: source bytes enter on the req_ channel, one per request, with byte 0
// ending a source text. Tokens leave on the rsp_ channel, one result per
// request there; a name longer than eight characters leaves as several chunk
// results, the last one flagged by rsp_last_of_token.
// The results of a byte go into the registered result queue on acceptance; from
// an empty queue the first reaches rsp_ the cycle after. The step logic is
// combinational, so the block takes one byte per cycle as long as results drain.
// A byte can cause up to four results (a three-chunk name plus the token
// that ended it). They go into an eight-entry result queue; req_ready is
// high while the queue has room for four more, and is taken from the
// registered fill level only. When the receiver stalls, the queue fills and
// req_ready drops until the receiver takes results again; a byte giving
// four results thus leaves them on rsp_ one after another.
// Reset empties the queue and returns the lexer to idle between tokens; the
// block accepts requests in the first cycle after reset.
module ir_token_lexer_core import irlex_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_source_char,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_token_kind,
   output logic [62:0] rsp_literal_mantissa,
   output logic [4:0]  rsp_fraction_digits,
   output logic [63:0] rsp_name_chunk,
   output logic [1:0]  rsp_chunk_index,
   output logic [4:0]  rsp_name_length,
   output logic [1:0]  rsp_error_code,
   output logic [7:0]  rsp_offending_byte,
   output logic        rsp_last_of_token
);

   lex_state_type                    state_ff, state_in;
   logic [NAME_LIMIT-1:0][7:0]       name_buf_ff;
   buf_write_type                    buf_write;
   lex_result_type [MAX_RESULTS-1:0] step_results;
   logic [RES_CNT_W-1:0]             step_count;

   lex_result_type [FIFO_DEPTH-1:0]  queue_ff;
   logic [FIFO_PTR_W-1:0]            wptr_ff, wptr_in;
   logic [FIFO_PTR_W-1:0]            rptr_ff, rptr_in;
   logic [FIFO_CNT_W-1:0]            count_ff, count_in;
   logic [RES_CNT_W-1:0]             push_count;
   logic                             accept;
   logic                             pop;
   lex_result_type                   head;

   irlex_step u_step (
      .cur_state    (state_ff),
      .name_buf     (name_buf_ff),
      .source_char  (req_source_char),
      .next_state   (state_in),
      .buf_write    (buf_write),
      .results      (step_results),
      .result_count (step_count)
   );

   assign req_ready  = (count_ff <= FIFO_CNT_W'(FIFO_DEPTH - MAX_RESULTS));
   assign accept     = req_valid && req_ready;
   assign rsp_valid  = (count_ff != '0);
   assign pop        = rsp_valid && rsp_ready;
   assign push_count = accept ? step_count : '0;

   assign wptr_in  = wptr_ff + FIFO_PTR_W'(push_count);
   assign rptr_in  = rptr_ff + FIFO_PTR_W'(pop);
   assign count_in = count_ff + FIFO_CNT_W'(push_count) - FIFO_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && buf_write.en) begin
         name_buf_ff[buf_write.addr] <= buf_write.data;
      end
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (RES_CNT_W'(i) < push_count) begin
            queue_ff[wptr_ff + FIFO_PTR_W'(i)] <= step_results[i];
         end
      end
   end

   assign head = queue_ff[rptr_ff];

   assign rsp_token_kind       = head.token_kind;
   assign rsp_literal_mantissa = head.literal_mantissa;
   assign rsp_fraction_digits  = head.fraction_digits;
   assign rsp_name_chunk       = head.name_chunk;
   assign rsp_chunk_index      = head.chunk_index;
   assign rsp_name_length      = head.name_length;
   assign rsp_error_code       = head.error_code;
   assign rsp_offending_byte   = head.offending_byte;
   assign rsp_last_of_token    = head.last_of_token;

endmodule

@@ rtl/core/irlex_step.sv @@
// Next-state and result logic for one source byte of the lexer.
module irlex_step import irlex_pkg::*; (
   input  lex_state_type                   cur_state,
   input  logic [NAME_LIMIT-1:0][7:0]      name_buf,
   input  logic [7:0]                      source_char,
   output lex_state_type                   next_state,
   output buf_write_type                   buf_write,
   output lex_result_type [MAX_RESULTS-1:0] results,
   output logic [RES_CNT_W-1:0]            result_count
);

   lex_result_type [NAME_CHUNKS-1:0] name_res;
   logic [RES_CNT_W-1:0]             name_res_count;
   lex_result_type                   lit_res;
   logic [66:0]                      mant_prod;
   logic [62:0]                      mant_next;
   logic [3:0]                       digit_val;

   assign digit_val = 4'(source_char - CH_ZERO);

   // Multiply by ten as two shifts; saturate when the value leaves 63 bits.
   always_comb begin
      mant_prod = ({4'b0, cur_state.mantissa} << 3) + ({4'b0, cur_state.mantissa} << 1) +
                  67'(digit_val);
      mant_next = (mant_prod > {4'b0, MANT_MAX}) ? MANT_MAX : mant_prod[62:0];
   end

   // Results of a finished name: a keyword, or one item per eight characters.
   always_comb begin
      logic [5:0]  len_sum;
      logic [63:0] word;
      int          idx;
      len_sum        = {1'b0, cur_state.name_count} + 6'd7;
      name_res       = '0;
      name_res_count = RES_CNT_W'(len_sum[5:3]);
      for (int i = 0; i < NAME_CHUNKS; i++) begin
         word = '0;
         for (int j = 0; j < 8; j++) begin
            idx = i * 8 + j;
            if (idx < NAME_LIMIT) begin
               if (5'(idx) < cur_state.name_count) begin
                  word[j*8 +: 8] = name_buf[idx];
               end
            end
         end
         name_res[i].token_kind    = KIND_IDENT;
         name_res[i].name_chunk    = word;
         name_res[i].chunk_index   = 2'(i);
         name_res[i].name_length   = cur_state.name_count;
         name_res[i].last_of_token = (RES_CNT_W'(i + 1) == name_res_count);
      end
      if (cur_state.name_count == 5'd5 &&
          {name_buf[0], name_buf[1], name_buf[2], name_buf[3], name_buf[4]} == KW_JMPIF) begin
         name_res       = '0;
         name_res[0]    = single_result(KIND_JMPIF);
         name_res_count = RES_CNT_W'(1);
      end else if (cur_state.name_count == 5'd3 &&
                   {name_buf[0], name_buf[1], name_buf[2]} == KW_JMP) begin
         name_res       = '0;
         name_res[0]    = single_result(KIND_JMP);
         name_res_count = RES_CNT_W'(1);
      end else if (cur_state.name_count == 5'd3 &&
                   {name_buf[0], name_buf[1], name_buf[2]} == KW_PHI) begin
         name_res       = '0;
         name_res[0]    = single_result(KIND_PHI);
         name_res_count = RES_CNT_W'(1);
      end
   end

   always_comb begin
      lit_res = single_result((cur_state.mode == MODE_FRAC) ? KIND_DECIMAL : KIND_INT);
      lit_res.literal_mantissa = cur_state.mantissa;
      lit_res.fraction_digits  = (cur_state.mode == MODE_FRAC) ? cur_state.frac_count : 5'd0;
   end

   always_comb begin
      logic                 do_start;
      logic [RES_CNT_W-1:0] flush_count;
      logic [RES_IDX_W-1:0] start_slot;
      logic                 start_emit;
      lex_result_type       start_res;
      next_state   = cur_state;
      buf_write    = '0;
      results      = '0;
      result_count = '0;
      do_start     = 1'b0;
      flush_count  = '0;
      start_slot   = '0;
      start_emit   = 1'b0;
      start_res    = '0;

      case (cur_state.mode)
         MODE_NAME: begin
            if (is_letter(source_char) || is_digit(source_char)) begin
               if (cur_state.name_count >= NAME_CNT_LIMIT) begin
                  results[0]      = error_result(ERR_NAME_LONG, CH_NUL);
                  result_count    = RES_CNT_W'(1);
                  next_state.mode = MODE_DROP;
               end else begin
                  buf_write.en          = 1'b1;
                  buf_write.addr        = cur_state.name_count[NAME_IDX_W-1:0];
                  buf_write.data        = source_char;
                  next_state.name_count = cur_state.name_count + 5'd1;
               end
            end else begin
               for (int i = 0; i < NAME_CHUNKS; i++) begin
                  results[i] = name_res[i];
               end
               flush_count = name_res_count;
               do_start    = 1'b1;
            end
         end
         MODE_INT, MODE_FRAC: begin
            if (is_digit(source_char)) begin
               if (cur_state.digit_count >= LIT_DIGIT_LIMIT) begin
                  results[0]      = error_result(ERR_LIT_LONG, CH_NUL);
                  result_count    = RES_CNT_W'(1);
                  next_state.mode = MODE_DROP;
               end else begin
                  next_state.mantissa    = mant_next;
                  next_state.digit_count = cur_state.digit_count + 5'd1;
                  if (cur_state.mode == MODE_FRAC) begin
                     next_state.frac_count = cur_state.frac_count + 5'd1;
                  end
               end
            end else if (source_char == CH_DOT && cur_state.mode == MODE_INT) begin
               next_state.mode = MODE_FRAC;
            end else begin
               results[0]  = lit_res;
               flush_count = RES_CNT_W'(1);
               do_start    = 1'b1;
            end
         end
         MODE_DROP: begin
            if (source_char == CH_NUL) begin
               next_state.mode = MODE_IDLE;
               results[0]      = single_result(KIND_END);
               result_count    = RES_CNT_W'(1);
            end
         end
         default: begin
            do_start = 1'b1;
         end
      endcase

      // The byte that ends a name or literal, or any byte in idle mode, opens the next token.
      if (do_start) begin
         next_state.mode = MODE_IDLE;
         case (source_char)
            CH_PLUS:   begin start_emit = 1'b1; start_res = single_result(KIND_ADD);    end
            CH_MINUS:  begin start_emit = 1'b1; start_res = single_result(KIND_MINUS);  end
            CH_STAR:   begin start_emit = 1'b1; start_res = single_result(KIND_MULT);   end
            CH_SLASH:  begin start_emit = 1'b1; start_res = single_result(KIND_DIV);    end
            CH_EQUAL:  begin start_emit = 1'b1; start_res = single_result(KIND_EQ);     end
            CH_COLON:  begin start_emit = 1'b1; start_res = single_result(KIND_COLON);  end
            CH_COMMA:  begin start_emit = 1'b1; start_res = single_result(KIND_COMMA);  end
            CH_LPAREN: begin start_emit = 1'b1; start_res = single_result(KIND_LPAREN); end
            CH_RPAREN: begin start_emit = 1'b1; start_res = single_result(KIND_RPAREN); end
            CH_SPACE, CH_TAB: begin
               start_emit = 1'b0;
            end
            CH_NUL: begin
               start_emit = 1'b1;
               start_res  = single_result(KIND_END);
            end
            default: begin
               if (is_letter(source_char)) begin
                  next_state.mode       = MODE_NAME;
                  next_state.name_count = 5'd1;
                  buf_write.en          = 1'b1;
                  buf_write.addr        = '0;
                  buf_write.data        = source_char;
               end else if (is_digit(source_char)) begin
                  next_state.mode        = MODE_INT;
                  next_state.mantissa    = 63'(digit_val);
                  next_state.digit_count = 5'd1;
                  next_state.frac_count  = 5'd0;
               end else begin
                  start_emit      = 1'b1;
                  start_res       = error_result(ERR_UNEXPECTED, source_char);
                  next_state.mode = MODE_DROP;
               end
            end
         endcase
         start_slot = flush_count[RES_IDX_W-1:0];
         if (start_emit) begin
            results[start_slot] = start_res;
         end
         result_count = flush_count + RES_CNT_W'(start_emit);
      end
   end

endmodule

@@ rtl/core/irlex_checker.sv @@
// Port-level assertions for the lexer core, bound to its top level.
`include "assert_macros.svh"

module irlex_checker import irlex_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [4:0]  rsp_token_kind,
   input logic [62:0] rsp_literal_mantissa,
   input logic [4:0]  rsp_fraction_digits,
   input logic [63:0] rsp_name_chunk,
   input logic [1:0]  rsp_chunk_index,
   input logic [4:0]  rsp_name_length,
   input logic [1:0]  rsp_error_code,
   input logic [7:0]  rsp_offending_byte,
   input logic        rsp_last_of_token
);

   lex_result_type rsp_payload;
   logic           rsp_stalled;
   logic           rsp_ident;
   logic           rsp_decimal;
   logic           single_fields_clear;
   logic [5:0]     chunk_start;

   assign rsp_payload = {rsp_token_kind, rsp_literal_mantissa, rsp_fraction_digits,
                         rsp_name_chunk, rsp_chunk_index, rsp_name_length, rsp_error_code,
                         rsp_offending_byte, rsp_last_of_token};
   assign rsp_stalled = rsp_valid && !rsp_ready;
   assign rsp_ident   = (rsp_token_kind == KIND_IDENT);
   assign rsp_decimal = (rsp_token_kind == KIND_DECIMAL);
   assign single_fields_clear = rsp_last_of_token && rsp_chunk_index == 2'd0 &&
                                rsp_name_length == 5'd0 && rsp_name_chunk == 64'd0;
   assign chunk_start = {1'b0, rsp_chunk_index, 3'b000};

   // Reset leaves no result pending.
   `CHK_ASSERT_NORST(a_reset_empty, clock, reset |=> !rsp_valid)

   // A result that is not taken stays put.
   `CHK_ASSERT(a_rsp_hold, clock, reset, rsp_stalled |=> rsp_valid && $stable(rsp_payload))

   // Only identifiers are split into chunks; every other token is one result.
   `CHK_ASSERT(a_single_result, clock, reset, rsp_valid && !rsp_ident |-> single_fields_clear)

   // Fraction digits appear on decimal literals only.
   `CHK_ASSERT(a_frac_decimal, clock, reset, rsp_valid && !rsp_decimal |-> rsp_fraction_digits == 5'd0)

   // An identifier chunk never lies beyond the name length.
   `CHK_ASSERT(a_chunk_in_name, clock, reset, rsp_valid && rsp_ident |-> chunk_start < {1'b0, rsp_name_length})

endmodule

bind ir_token_lexer_core irlex_checker u_irlex_checker (.*);
